// File: sv/bccr_pkg.sv
package bccr_pkg;

   localparam int ROW_BITS    = 6;
   localparam int COL_BITS    = 6;
   localparam int ADDR_BITS   = ROW_BITS + COL_BITS;
   localparam int SAMPLE_BITS = 16;
   localparam int COUNT_BITS  = 7;
   localparam int WEIGHT_BITS = 20;
   localparam int CSR_ADDR_BITS = 5;

   localparam logic [COUNT_BITS-1:0] MAX_ROWS = 7'd64;
   localparam logic [COUNT_BITS-1:0] MAX_COLS = 7'd64;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic signed [WEIGHT_BITS-1:0] weight_type;
   typedef weight_type weight_set_type [4];

   typedef enum logic {
      CMD_LOAD  = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      REG_X_ORIGIN   = 3'd0,
      REG_Y_ORIGIN   = 3'd1,
      REG_X_INV_STEP = 3'd2,
      REG_Y_INV_STEP = 3'd3,
      REG_ROW_COUNT  = 3'd4,
      REG_COL_COUNT  = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOCATE,
      S_FETCH,
      S_ROW,
      S_ROUND,
      S_OUT
   } state_type;

   // clamp a register count to 1..max
   function automatic logic [COUNT_BITS-1:0] eff_count(
      input logic [COUNT_BITS-1:0] c,
      input logic [COUNT_BITS-1:0] maxv
   );
      logic [COUNT_BITS-1:0] r;
      if (c == '0) begin
         r = COUNT_BITS'(1);
      end else if (c > maxv) begin
         r = maxv;
      end else begin
         r = c;
      end
      return r;
   endfunction

endpackage

// File: sv/bccr_grid_mem.sv
module bccr_grid_mem
   import bccr_pkg::*;
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] addr,
   input  sample_type           wr_data,
   output sample_type           rd_data
);

   sample_type mem [2**ADDR_BITS];
   sample_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/bccr_coord.sv
module bccr_coord
   import bccr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  logic [31:0]           query,
   input  logic [31:0]           origin,
   input  logic [31:0]           inv_step,
   input  logic [COUNT_BITS-1:0] count,
   output logic                  done,
   output logic [ROW_BITS-1:0]   cell_idx,
   output weight_set_type        weight
);

   localparam logic [3:0] STEP_LAST = 4'd12;
   localparam logic signed [51:0] TWO_S48 = 52'sd1 <<< 49;
   localparam logic signed [51:0] HALF_S32 = 52'sd1 <<< 31;

   logic [3:0]            step_ff, step_in;
   logic signed [32:0]    dx_ff;
   logic signed [49:0]    prod_hi_ff, prod_lo_ff, t_ff;
   logic [15:0]           frac_ff;
   logic [31:0]           u2_ff;
   logic [47:0]           u3_ff;
   logic [31:0]           bits_ff;
   logic [ROW_BITS-1:0]   rem_ff, rem_in;
   logic [COUNT_BITS-1:0] r;
   logic signed [51:0]    u1e, u2e, u3e;
   logic signed [51:0]    e [4];
   weight_type            weight_ff [4];

   // step counter
   always_comb begin
      step_in = step_ff;
      if (go) begin
         step_in = 4'd1;
      end else if (step_ff == STEP_LAST) begin
         step_in = '0;
      end else if (step_ff != '0) begin
         step_in = step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   // floor modulo, four bits a step, msb carries weight -2^32
   always_comb begin
      r = {1'b0, rem_ff};
      for (int k = 0; k < 4; k++) begin
         r = {r[COUNT_BITS-2:0], bits_ff[31-k]};
         if (r >= count) begin
            r = r - count;
         end
      end
      rem_in = r[ROW_BITS-1:0];
   end

   always_comb begin
      u1e = $signed({36'd0, frac_ff});
      u2e = $signed({20'd0, u2_ff});
      u3e = $signed({4'd0, u3_ff});
      e[0] = -u3e + (u2e <<< 17) - (u1e <<< 32);
      e[1] = (u3e <<< 1) + u3e - (u2e <<< 18) - (u2e <<< 16) + TWO_S48;
      e[2] = -(u3e <<< 1) - u3e + (u2e <<< 18) + (u1e <<< 32);
      e[3] = u3e - (u2e <<< 16);
   end

   always_ff @(posedge clock) begin
      if (go) begin
         dx_ff <= $signed({query[31], query}) - $signed({origin[31], origin});
      end
      case (step_ff)
         4'd1: begin
            prod_hi_ff <= dx_ff * $signed({1'b0, inv_step[31:16]});
            prod_lo_ff <= dx_ff * $signed({1'b0, inv_step[15:0]});
         end
         4'd2: begin
            t_ff <= prod_hi_ff + 50'(prod_lo_ff >>> 16);
         end
         4'd3: begin
            frac_ff <= t_ff[15:0];
            bits_ff <= t_ff[47:16];
            rem_ff  <= t_ff[48] ? ROW_BITS'(count - COUNT_BITS'(1)) : '0;
         end
         default: begin
            rem_ff  <= rem_in;
            bits_ff <= {bits_ff[27:0], 4'd0};
         end
      endcase
      if (step_ff == 4'd4) begin
         u2_ff <= frac_ff * frac_ff;
      end
      if (step_ff == 4'd5) begin
         u3_ff <= u2_ff * frac_ff;
      end
      if (step_ff == 4'd6) begin
         for (int k = 0; k < 4; k++) begin
            weight_ff[k] <= WEIGHT_BITS'((e[k] + HALF_S32) >>> 32);
         end
      end
   end

   assign done     = (step_ff == STEP_LAST);
   assign cell_idx = rem_ff;
   assign weight   = weight_ff;

endmodule

// File: sv/bicubic_catmull_rom_cyclic_interp.sv
// channel   | handshake          | payload
// request   | start / busy       | req_cmd, req_load_row, req_load_col, req_load_value,
//           |                    | req_query_x, req_query_y
// result    | rsp_strobe         | rsp_interp_value, rsp_saturated
// registers | psel/penable/pready| paddr, pwrite, pwdata, prdata
//
// a load is written at the accepting edge, busy stays low
// a query holds busy through to its result strobe, which comes while busy is still
// high; the cell is located first (multiply, then a four-bits-a-cycle wrap), then
// sixteen reads from the single-port sample memory plus pipeline drain, then the
// row pass, a state to round and a state to present the result
// synchronous reset clears control and registers; the grid holds no reset
// the result is shown for one cycle only, the receiver cannot stall it
module bicubic_catmull_rom_cyclic_interp
   import bccr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_cmd,
   input  logic [5:0]               req_load_row,
   input  logic [5:0]               req_load_col,
   input  logic signed [15:0]       req_load_value,
   input  logic signed [31:0]       req_query_x,
   input  logic signed [31:0]       req_query_y,
   output logic                     rsp_strobe,
   output logic signed [15:0]       rsp_interp_value,
   output logic                     rsp_saturated,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   // configuration registers
   logic [31:0]           x_origin_ff, y_origin_ff, x_inv_ff, y_inv_ff;
   logic [COUNT_BITS-1:0] row_count_ff, col_count_ff;
   logic [COUNT_BITS-1:0] nr, nc;
   logic                  csr_wr;
   reg_index_type         csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = reg_index_type'(paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         x_origin_ff  <= '0;
         y_origin_ff  <= '0;
         x_inv_ff     <= 32'd65536;
         y_inv_ff     <= 32'd65536;
         row_count_ff <= MAX_ROWS;
         col_count_ff <= MAX_COLS;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_X_ORIGIN:   x_origin_ff  <= pwdata;
            REG_Y_ORIGIN:   y_origin_ff  <= pwdata;
            REG_X_INV_STEP: x_inv_ff     <= pwdata;
            REG_Y_INV_STEP: y_inv_ff     <= pwdata;
            REG_ROW_COUNT:  row_count_ff <= pwdata[COUNT_BITS-1:0];
            REG_COL_COUNT:  col_count_ff <= pwdata[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_X_ORIGIN:   prdata = x_origin_ff;
         REG_Y_ORIGIN:   prdata = y_origin_ff;
         REG_X_INV_STEP: prdata = x_inv_ff;
         REG_Y_INV_STEP: prdata = y_inv_ff;
         REG_ROW_COUNT:  prdata = {25'd0, row_count_ff};
         REG_COL_COUNT:  prdata = {25'd0, col_count_ff};
         default:        prdata = '0;
      endcase
   end

   // counts in use after clamping
   assign nr = eff_count(row_count_ff, MAX_ROWS);
   assign nc = eff_count(col_count_ff, MAX_COLS);

   // control
   state_type state_ff, state_in;
   logic      accept, query_go, load_we, issuing, x_done, y_done;
   logic [4:0] issue_cnt_ff;
   logic [2:0] row_cnt_ff;

   assign accept   = start & ~busy;
   assign query_go = accept & (req_cmd == CMD_QUERY);
   assign load_we  = accept & (req_cmd == CMD_LOAD);

   // coordinate units: cell, wrap and weights per axis
   logic [ROW_BITS-1:0] cell_x, cell_y;
   weight_set_type      wu, wv;

   bccr_coord u_coord_x (
      .clock    (clock),
      .reset    (reset),
      .go       (query_go),
      .query    (req_query_x),
      .origin   (x_origin_ff),
      .inv_step (x_inv_ff),
      .count    (nr),
      .done     (x_done),
      .cell_idx (cell_x),
      .weight   (wu)
   );

   bccr_coord u_coord_y (
      .clock    (clock),
      .reset    (reset),
      .go       (query_go),
      .query    (req_query_y),
      .origin   (y_origin_ff),
      .inv_step (y_inv_ff),
      .count    (nc),
      .done     (y_done),
      .cell_idx (cell_y),
      .weight   (wv)
   );

   // column pass pipeline: read, multiply, accumulate
   logic                       rd_vld_ff, mul_vld_ff, mul2_vld_ff;
   logic [3:0]                 rd_tag_ff, mul_tag_ff;
   logic signed [35:0]         mul_ff;
   logic signed [37:0]         col_acc_ff, col_sum;
   logic signed [28:0]         mid_ff [4];
   logic signed [48:0]         mul2_ff;
   logic signed [50:0]         row_acc_ff;
   logic signed [25:0]         res;
   logic                       fetch_end;

   // neighbourhood pointers
   logic [ROW_BITS-1:0] row_ptr_ff, col_ptr_ff, col_first_ff;
   logic [ROW_BITS-1:0] row_next, col_next;
   logic [ADDR_BITS-1:0] mem_addr;
   sample_type           mem_rd;

   assign row_next = (COUNT_BITS'(row_ptr_ff) + COUNT_BITS'(1) == nr) ? '0
                     : row_ptr_ff + ROW_BITS'(1);
   assign col_next = (COUNT_BITS'(col_ptr_ff) + COUNT_BITS'(1) == nc) ? '0
                     : col_ptr_ff + ROW_BITS'(1);

   assign mem_addr = load_we ? {req_load_row, req_load_col} : {row_ptr_ff, col_ptr_ff};

   bccr_grid_mem u_grid (
      .clock   (clock),
      .wr_en   (load_we),
      .addr    (mem_addr),
      .wr_data (req_load_value),
      .rd_data (mem_rd)
   );

   assign fetch_end = mul_vld_ff & (mul_tag_ff == 4'd15);
   assign col_sum   = col_acc_ff + 38'(mul_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (query_go) state_in = S_LOCATE;
         S_LOCATE: if (x_done & y_done) state_in = S_FETCH;
         S_FETCH:  if (fetch_end) state_in = S_ROW;
         S_ROW:    if (row_cnt_ff == 3'd4) state_in = S_ROUND;
         S_ROUND:  state_in = S_OUT;
         S_OUT:    state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs of the state machine
   always_comb begin
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      issuing    = 1'b0;
      case (state_ff)
         S_IDLE:  busy = 1'b0;
         S_FETCH: issuing = ~issue_cnt_ff[4];
         S_OUT:   rsp_strobe = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rd_vld_ff   <= 1'b0;
         mul_vld_ff  <= 1'b0;
         mul2_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_vld_ff   <= issuing;
         mul_vld_ff  <= rd_vld_ff;
         mul2_vld_ff <= (state_ff == S_ROW) & ~row_cnt_ff[2];
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rd_tag_ff  <= issue_cnt_ff[3:0];
      mul_tag_ff <= rd_tag_ff;
      mul_ff     <= wv[rd_tag_ff[1:0]] * mem_rd;

      if (state_ff == S_LOCATE) begin
         // first neighbour sits one cell before the located one, wrapped
         row_ptr_ff   <= (cell_x == '0) ? ROW_BITS'(nr - COUNT_BITS'(1)) : cell_x - ROW_BITS'(1);
         col_ptr_ff   <= (cell_y == '0) ? ROW_BITS'(nc - COUNT_BITS'(1)) : cell_y - ROW_BITS'(1);
         col_first_ff <= (cell_y == '0) ? ROW_BITS'(nc - COUNT_BITS'(1)) : cell_y - ROW_BITS'(1);
         issue_cnt_ff <= '0;
         col_acc_ff   <= '0;
      end else if (issuing) begin
         issue_cnt_ff <= issue_cnt_ff + 5'd1;
         if (issue_cnt_ff[1:0] == 2'd3) begin
            row_ptr_ff <= row_next;
            col_ptr_ff <= col_first_ff;
         end else begin
            col_ptr_ff <= col_next;
         end
      end

      if (mul_vld_ff) begin
         if (mul_tag_ff[1:0] == 2'd3) begin
            // round half up to 2^-8
            mid_ff[mul_tag_ff[3:2]] <= 29'((col_sum + 38'sd256) >>> 9);
            col_acc_ff <= '0;
         end else begin
            col_acc_ff <= col_sum;
         end
      end

      // row pass
      if (state_ff == S_FETCH) begin
         row_cnt_ff <= '0;
         row_acc_ff <= '0;
      end else if (state_ff == S_ROW) begin
         row_cnt_ff <= row_cnt_ff + 3'd1;
         mul2_ff    <= wu[row_cnt_ff[1:0]] * mid_ff[row_cnt_ff[1:0]];
         if (mul2_vld_ff) begin
            row_acc_ff <= row_acc_ff + 51'(mul2_ff);
         end
      end

      // round to an integer and saturate
      if (state_ff == S_ROUND) begin
         if (res > 26'sd32767) begin
            rsp_interp_value <= 16'sh7fff;
            rsp_saturated    <= 1'b1;
         end else if (res < -26'sd32768) begin
            rsp_interp_value <= 16'sh8000;
            rsp_saturated    <= 1'b1;
         end else begin
            rsp_interp_value <= res[15:0];
            rsp_saturated    <= 1'b0;
         end
      end
   end

   assign res = 26'((row_acc_ff + (51'sd1 <<< 24)) >>> 25);

endmodule

// File: sv/bccr_checker.sv
module bccr_checker
   import bccr_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               req_cmd,
   input logic               rsp_strobe,
   input logic signed [15:0] rsp_interp_value,
   input logic               rsp_saturated
);

   // a result lasts one cycle
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held");

   // results only come while a query is in flight
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> busy)
      else $error("result outside a query");

   // a query makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CMD_QUERY) |=> busy)
      else $error("query not taken");

   // a load gives no result and no busy time
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_cmd == CMD_LOAD) |=> (!busy && !rsp_strobe))
      else $error("load misbehaved");

   // a clipped value sits at a rail
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_saturated) |->
         (rsp_interp_value == 16'sh7fff || rsp_interp_value == 16'sh8000))
      else $error("saturated value off the rails");

endmodule

bind bicubic_catmull_rom_cyclic_interp bccr_checker u_bccr_checker (.*);

// File: tb/tb.sv
module tb;
   import bccr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PROGRESS_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 60;
   localparam int FILL_SIZE      = 16;

   typedef struct {
      sample_type value;
      logic       clipped;
   } spline_result_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic                     req_cmd;
   logic [5:0]               req_load_row;
   logic [5:0]               req_load_col;
   logic signed [15:0]       req_load_value;
   logic signed [31:0]       req_query_x;
   logic signed [31:0]       req_query_y;
   logic                     rsp_strobe;
   logic signed [15:0]       rsp_interp_value;
   logic                     rsp_saturated;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [31:0]              pwdata;
   logic [31:0]              prdata;
   logic                     pready;

   // shadow of the block's registers and sample grid
   logic signed [31:0] x_origin_q, y_origin_q;
   logic [31:0]        x_inv_q, y_inv_q;
   logic [6:0]         rows_q, cols_q;
   sample_type         grid_shadow [4096];

   spline_result_type  pending_results [$];
   int                 error_count;
   int                 sender_idle_pct;
   longint             progress_count;
   longint             watched_progress;
   int                 quiet_cycles;

   bicubic_catmull_rom_cyclic_interp u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_load_row     (req_load_row),
      .req_load_col     (req_load_col),
      .req_load_value   (req_load_value),
      .req_query_x      (req_query_x),
      .req_query_y      (req_query_y),
      .rsp_strobe       (rsp_strobe),
      .rsp_interp_value (rsp_interp_value),
      .rsp_saturated    (rsp_saturated),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // floor division, c-style division rounds towards zero
   function automatic longint floor_div(input longint a, input longint d);
      longint q;
      q = a / d;
      if ((a % d) != 0 && ((a < 0) != (d < 0))) begin
         q = q - 1;
      end
      return q;
   endfunction

   function automatic longint clamp_count(input logic [6:0] c);
      longint n;
      n = c;
      if (n == 0) begin
         n = 1;
      end else if (n > 64) begin
         n = 64;
      end
      return n;
   endfunction

   // scale against origin, split into wrapped cell and q0.16 fraction
   function automatic void find_cell(input logic signed [31:0] pos,
                                     input logic signed [31:0] org,
                                     input logic [31:0] inv, input longint n,
                                     output longint cell_idx, output longint frac);
      longint dx, t, c, r;
      dx = longint'(pos) - longint'(org);
      t = dx * longint'(inv >> 16) + floor_div(dx * longint'(inv & 32'hffff), 65536);
      c = floor_div(t, 65536);
      frac = t - c * 65536;
      r = c % n;
      if (r < 0) begin
         r = r + n;
      end
      cell_idx = r;
   endfunction

   // doubled catmull-rom weights in units of 2^-16
   function automatic void spline_weights(input longint u, output longint w [4]);
      longint u2, u3;
      longint e [4];
      u2 = u * u;
      u3 = u2 * u;
      e[0] = -u3 + 2 * u2 * 65536 - u * (longint'(1) << 32);
      e[1] = 3 * u3 - 5 * u2 * 65536 + 2 * (longint'(1) << 48);
      e[2] = -3 * u3 + 4 * u2 * 65536 + u * (longint'(1) << 32);
      e[3] = u3 - u2 * 65536;
      for (int k = 0; k < 4; k++) begin
         w[k] = floor_div(e[k] + (longint'(1) << 31), longint'(1) << 32);
      end
   endfunction

   function automatic spline_result_type interpolate(input logic signed [31:0] qx,
                                                     input logic signed [31:0] qy);
      spline_result_type res;
      longint nr, nc, ci, cj, fu, fv, acc, v, r, c;
      longint wu [4];
      longint wv [4];
      longint mid [4];
      nr = clamp_count(rows_q);
      nc = clamp_count(cols_q);
      find_cell(qx, x_origin_q, x_inv_q, nr, ci, fu);
      find_cell(qy, y_origin_q, y_inv_q, nc, cj, fv);
      spline_weights(fu, wu);
      spline_weights(fv, wv);
      for (int i = 0; i < 4; i++) begin
         r = (ci + nr + i - 1) % nr;
         acc = 0;
         for (int j = 0; j < 4; j++) begin
            c = (cj + nc + j - 1) % nc;
            acc = acc + wv[j] * longint'(grid_shadow[r * 64 + c]);
         end
         mid[i] = floor_div(acc + 256, 512);
      end
      acc = 0;
      for (int i = 0; i < 4; i++) begin
         acc = acc + wu[i] * mid[i];
      end
      v = floor_div(acc + (longint'(1) << 24), longint'(1) << 25);
      res.clipped = 1'b0;
      if (v > 32767) begin
         v = 32767;
         res.clipped = 1'b1;
      end
      if (v < -32768) begin
         v = -32768;
         res.clipped = 1'b1;
      end
      res.value = sample_type'(v);
      return res;
   endfunction

   // one request, held until the block takes it
   task automatic send_request(input cmd_type cmd, input logic [5:0] row, input logic [5:0] col,
                               input sample_type value, input logic signed [31:0] qx,
                               input logic signed [31:0] qy);
      int gap;
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         gap = $urandom_range(6, 1);
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_cmd        <= cmd;
      req_load_row   <= row;
      req_load_col   <= col;
      req_load_value <= value;
      req_query_x    <= qx;
      req_query_y    <= qy;
      @(posedge clock);
      while (busy) @(posedge clock);
      progress_count++;
      if (cmd == CMD_LOAD) begin
         grid_shadow[row * 64 + col] = value;
      end else begin
         pending_results.push_back(interpolate(qx, qy));
      end
   endtask

   task automatic load_sample(input int row, input int col, input sample_type value);
      send_request(CMD_LOAD, 6'(row), 6'(col), value, $urandom, $urandom);
   endtask

   task automatic query_point(input logic signed [31:0] qx, input logic signed [31:0] qy);
      send_request(CMD_QUERY, 6'($urandom), 6'($urandom), 16'($urandom), qx, qy);
   endtask

   // let everything drain, loads leave no result so pad for a whole query
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (45) @(posedge clock);
   endtask

   task automatic write_register(input reg_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_BITS'(idx) << 2;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      progress_count++;
      case (idx)
         REG_X_ORIGIN:   x_origin_q = value;
         REG_Y_ORIGIN:   y_origin_q = value;
         REG_X_INV_STEP: x_inv_q    = value;
         REG_Y_INV_STEP: y_inv_q    = value;
         REG_ROW_COUNT:  rows_q     = value[6:0];
         REG_COL_COUNT:  cols_q     = value[6:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_geometry(input logic [31:0] xo, input logic [31:0] yo,
                               input logic [31:0] xi, input logic [31:0] yi,
                               input logic [31:0] nr, input logic [31:0] nc);
      wait_idle();
      write_register(REG_X_ORIGIN, xo);
      write_register(REG_Y_ORIGIN, yo);
      write_register(REG_X_INV_STEP, xi);
      write_register(REG_Y_INV_STEP, yi);
      write_register(REG_ROW_COUNT, nr);
      write_register(REG_COL_COUNT, nc);
   endtask

   // the corner square plus all of row 0 and column 0: counts up to FILL_SIZE
   // and the one-row or one-column geometries only ever read loaded samples
   task automatic test_fill_grid();
      for (int r = 0; r < FILL_SIZE; r++) begin
         for (int c = 0; c < FILL_SIZE; c++) begin
            load_sample(r, c, 16'($urandom));
         end
      end
      for (int k = FILL_SIZE; k < 64; k++) begin
         load_sample(0, k, 16'($urandom));
         load_sample(k, 0, 16'($urandom));
      end
   endtask

   task automatic test_directed();
      // a checkerboard of rail samples inside the corner
      load_sample(1, 1, 16'sh7fff);
      load_sample(1, 2, -16'sh8000);
      load_sample(2, 1, -16'sh8000);
      load_sample(2, 2, 16'sh7fff);
      // reset geometry, neighbourhoods kept inside the loaded corner
      query_point(32'sh0001_8000, 32'sh0001_8000);
      query_point(32'sh0001_c000, 32'sh0001_4000);
      query_point(32'sh000c_0000, 32'sh0005_ffff);
      // wrap in both directions on a small grid
      set_geometry(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'd16, 32'd16);
      query_point(32'sh0, 32'sh0);
      query_point(32'sh7fff_ffff, 32'sh7fff_ffff);
      query_point(-32'sh8000_0000, -32'sh8000_0000);
      query_point(-32'sh0000_0001, 32'sh0000_ffff);
      query_point(-32'sh0003_4000, 32'sh0040_2000);
      // zero inverse step, one row against clamped oversized columns
      set_geometry(32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0, 32'd0, 32'd127);
      query_point(32'sh1234_5678, -32'sh0000_0100);
      query_point(32'sh7fff_ffff, -32'sh8000_0000);
      // clamped oversized rows against one column
      set_geometry(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h1, 32'd65, 32'd1);
      query_point(-32'sh8000_0000, 32'sh7fff_ffff);
      query_point(32'sh0000_0001, 32'sh0);
      query_point(32'sh7fff_ffff, -32'sh8000_0000);
      set_geometry(32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 32'd16, 32'd16);
   endtask

   task automatic test_random(input int count, input int idle_pct);
      logic signed [31:0] qx, qy;
      sender_idle_pct = idle_pct;
      set_geometry($urandom, $urandom,
                   ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0004_0000, 1),
                   ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0004_0000, 1),
                   ($urandom_range(7) == 0) ? 32'd0 : $urandom_range(FILL_SIZE, 1),
                   ($urandom_range(7) == 0) ? 32'd0 : $urandom_range(FILL_SIZE, 1));
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 25) begin
            load_sample($urandom_range(63), $urandom_range(63), 16'($urandom));
         end else begin
            // mostly near the grid origin so fractions and wraps stay meaningful
            if ($urandom_range(3) == 0) begin
               qx = $urandom;
               qy = $urandom;
            end else begin
               qx = x_origin_q + $signed(32'($urandom_range(32'h0080_0000))) - 32'sh0040_0000;
               qy = y_origin_q + $signed(32'($urandom_range(32'h0080_0000))) - 32'sh0040_0000;
            end
            query_point(qx, qy);
         end
      end
      sender_idle_pct = 0;
   endtask

   // result checker, the receiver cannot stall so every strobe is taken
   always @(posedge clock) begin
      spline_result_type want;
      if (!reset && rsp_strobe) begin
         progress_count++;
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result: expected none, actual value %0d saturated %0b",
                     $time, rsp_interp_value, rsp_saturated);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_interp_value !== want.value) begin
               $display("%0t interp_value mismatch: expected %0d, actual %0d",
                        $time, want.value, rsp_interp_value);
               error_count++;
            end
            if (rsp_saturated !== want.clipped) begin
               $display("%0t saturated mismatch: expected %0b, actual %0b",
                        $time, want.clipped, rsp_saturated);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (progress_count != watched_progress) begin
         watched_progress <= progress_count;
         quiet_cycles     <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= PROGRESS_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_cmd          = CMD_LOAD;
      req_load_row     = '0;
      req_load_col     = '0;
      req_load_value   = '0;
      req_query_x      = '0;
      req_query_y      = '0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      error_count      = 0;
      sender_idle_pct  = 0;
      progress_count   = 0;
      watched_progress = 0;
      quiet_cycles     = 0;
      x_origin_q       = '0;
      y_origin_q       = '0;
      x_inv_q          = 32'h0001_0000;
      y_inv_q          = 32'h0001_0000;
      rows_q           = 7'd64;
      cols_q           = 7'd64;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_grid();
      test_directed();
      test_random(110, 0);
      test_random(110, 47);
      test_random(110, 20);
      test_random(110, 0);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/bccr_pkg.sv
sv/bccr_grid_mem.sv
sv/bccr_coord.sv
sv/bicubic_catmull_rom_cyclic_interp.sv
sv/bccr_checker.sv
tb/tb.sv
